// ----- hw/rtl/m3i_pkg.sv -----
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants for the 3x3 matrix inverse unit: element counts, field
// widths, the cofactor index table and parameter defaults.
// ----------------------------------------------------------------------------
package m3i_pkg;

  // Parameter defaults for the top level.
  localparam int unsigned ELEM_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Every element travels in a 32-bit field on the stream buses.
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned NUM_ELEMS = 9;

  // Index of one of the nine elements or results.
  typedef logic [3:0] idx_t;
  localparam idx_t LAST_IDX = idx_t'(NUM_ELEMS - 1);

  // Adjugate entry k is a[p]*a[q] - a[r]*a[s], elements in row-major order.
  localparam idx_t ADJ_IDX [NUM_ELEMS][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage

// ----- hw/rtl/m3i_front.sv -----
// ----------------------------------------------------------------------------
// m3i_front
// Five-stage pipeline that takes a matrix and forms the nine exact cofactors
// and the determinant by expansion along the first row.
// ----------------------------------------------------------------------------
module m3i_front import m3i_pkg::*; #(
  parameter int unsigned ElemWidth = ELEM_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [NUM_ELEMS*FIELD_W-1:0]           in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [NUM_ELEMS*(2*ElemWidth+1)-1:0]   out_adj_o,
  output logic [3*ElemWidth+2:0]                 out_det_o
);

  localparam int unsigned W  = ElemWidth;
  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned DW = 3 * W + 3;
  localparam int unsigned NSTAGE = 5;

  logic                    en;
  logic [NSTAGE-1:0]       vld_q;
  logic signed [W-1:0]     elem [NUM_ELEMS];

  logic signed [2*W-1:0]   prod_q [2*NUM_ELEMS];
  logic signed [W-1:0]     row1_q [3];
  logic signed [W-1:0]     row2_q [3];
  logic signed [CW-1:0]    adj2_q [NUM_ELEMS];
  logic signed [CW-1:0]    adj3_q [NUM_ELEMS];
  logic signed [CW-1:0]    adj4_q [NUM_ELEMS];
  logic signed [CW-1:0]    adj5_q [NUM_ELEMS];
  logic signed [2*W:0]     mlo_q  [3];
  logic signed [2*W:0]     mhi_q  [3];
  logic signed [DW-1:0]    term_q [3];
  logic signed [DW-1:0]    det_q;

  // The whole pipeline advances unless its last stage is held by the queue.
  assign en          = !vld_q[NSTAGE-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NSTAGE-1];

  // Elements are the low ElemWidth bits of each field, read as signed.
  always_comb begin
    for (int k = 0; k < NUM_ELEMS; k++) begin
      elem[k] = in_data_i[k*FIELD_W +: W];
    end
  end

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTAGE-2:0], in_valid_i};
    end
  end

  // Datapath: products, cofactors, split products, terms, determinant.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_ELEMS; k++) begin
        prod_q[2*k]   <= elem[ADJ_IDX[k][0]] * elem[ADJ_IDX[k][1]];
        prod_q[2*k+1] <= elem[ADJ_IDX[k][2]] * elem[ADJ_IDX[k][3]];
        adj2_q[k]     <= CW'(prod_q[2*k]) - CW'(prod_q[2*k+1]);
        adj3_q[k]     <= adj2_q[k];
        adj4_q[k]     <= adj3_q[k];
        adj5_q[k]     <= adj4_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        row1_q[j] <= elem[j];
        row2_q[j] <= row1_q[j];
        // Cofactor split into an unsigned low word and a signed high part.
        mlo_q[j]  <= row2_q[j] * $signed({1'b0, adj2_q[3*j][W-1:0]});
        mhi_q[j]  <= row2_q[j] * $signed(adj2_q[3*j][CW-1:W]);
        term_q[j] <= (DW'(mhi_q[j]) <<< W) + DW'(mlo_q[j]);
      end
      det_q <= term_q[0] + term_q[1] + term_q[2];
    end
  end

  // Pack the cofactors for the queue.
  always_comb begin
    for (int k = 0; k < NUM_ELEMS; k++) begin
      out_adj_o[k*CW +: CW] = adj5_q[k];
    end
  end
  assign out_det_o = det_q;

endmodule

// ----- hw/rtl/m3i_queue.sv -----
// ----------------------------------------------------------------------------
// m3i_queue
// Two-entry queue that decouples the cofactor front end from the divider.
// ----------------------------------------------------------------------------
module m3i_queue import m3i_pkg::*; #(
  parameter int unsigned DataWidth = NUM_ELEMS * FIELD_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  logic [DataWidth-1:0] push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output logic [DataWidth-1:0] pop_data_o
);

  logic [DataWidth-1:0] mem_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q;
  logic                 push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/m3i_back.sv -----
// ----------------------------------------------------------------------------
// m3i_back
// Issues the nine cofactors of a queued matrix to a pipelined restoring
// divider, one per cycle unless held, saturates the quotients and gathers
// them into an assembly buffer ahead of the output register.
// ----------------------------------------------------------------------------
module m3i_back import m3i_pkg::*; #(
  parameter int unsigned ElemWidth = ELEM_WIDTH_DEF,
  parameter int unsigned FracBits  = FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [NUM_ELEMS*(2*ElemWidth+1)-1:0]  in_adj_i,
  input  logic [3*ElemWidth+2:0]                in_det_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [NUM_ELEMS*FIELD_W-1:0]          out_data_o,
  output logic                                  out_singular_o
);

  localparam int unsigned W    = ElemWidth;
  localparam int unsigned CW   = 2 * W + 1;
  localparam int unsigned DW   = 3 * W + 3;
  localparam int unsigned NW   = CW + 2 * FracBits;
  localparam int unsigned HW   = NW - W;
  localparam int unsigned CMPW = (HW > DW) ? HW : DW;

  logic                 div_en, issue, move;
  idx_t                 cnt_q;

  // Issue stage.
  logic signed [CW-1:0] adj_sel;
  logic signed [DW-1:0] det_sel;
  logic [CW-1:0]        adj_mag;
  logic [DW-1:0]        det_mag;
  logic                 iv_q, ineg_q, ising_q;
  logic [NW-1:0]        inum_q;
  logic [DW-1:0]        iden_q;
  idx_t                 iidx_q;

  // Range check and divider steps; entry 0 is the checked value.
  logic [CMPW-1:0]      hi_ext, den_ext;
  logic                 sv_q   [W+1];
  logic [DW-1:0]        rem_q  [W+1];
  logic [W-1:0]         low_q  [W+1];
  logic [W-1:0]         quo_q  [W+1];
  logic [DW-1:0]        den_q  [W+1];
  logic                 neg_q  [W+1];
  logic                 sing_q [W+1];
  logic                 ovf_q  [W+1];
  idx_t                 idx_q  [W+1];

  // Result forming and assembly.
  logic [W-1:0]         lim, mag, sres;
  logic [FIELD_W-1:0]   res;
  logic [FIELD_W-1:0]   asm_q [NUM_ELEMS];
  logic                 asm_sing_q, asm_full_q;
  logic [NUM_ELEMS*FIELD_W-1:0] out_data_q;
  logic                 out_valid_q, out_sing_q;

  // The divider holds while a finished matrix waits for the output register.
  assign move       = asm_full_q && (!out_valid_q || out_ready_i);
  assign div_en     = !asm_full_q || move;
  assign issue      = div_en && in_valid_i;
  assign in_ready_o = issue && (cnt_q == LAST_IDX);

  // Select the cofactor for this cycle and take magnitudes.
  always_comb begin
    adj_sel = in_adj_i[cnt_q*CW +: CW];
    det_sel = in_det_i;
    adj_mag = adj_sel[CW-1] ? CW'(-adj_sel) : CW'(adj_sel);
    det_mag = det_sel[DW-1] ? DW'(-det_sel) : DW'(det_sel);
  end

  // Range check: the quotient fits in ElemWidth bits when num < den * 2^W.
  assign hi_ext  = CMPW'(inum_q >> W);
  assign den_ext = CMPW'(iden_q);

  // Control state of issue, divider and assembly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      iv_q        <= 1'b0;
      asm_full_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= W; i++) sv_q[i] <= 1'b0;
    end else begin
      if (div_en) begin
        iv_q    <= issue;
        sv_q[0] <= iv_q;
        for (int i = 0; i < W; i++) sv_q[i+1] <= sv_q[i];
        if (issue) cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + idx_t'(1);
      end
      asm_full_q <= (asm_full_q && !move) ||
                    (div_en && sv_q[W] && (idx_q[W] == LAST_IDX));
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider datapath: one quotient bit per stage.
  always_ff @(posedge clk_i) begin
    if (div_en) begin
      inum_q  <= {adj_mag, {(2*FracBits){1'b0}}};
      iden_q  <= det_mag;
      ineg_q  <= adj_sel[CW-1] ^ det_sel[DW-1];
      ising_q <= (det_sel == '0);
      iidx_q  <= cnt_q;

      rem_q[0]  <= hi_ext[DW-1:0];
      low_q[0]  <= inum_q[W-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= iden_q;
      neg_q[0]  <= ineg_q;
      sing_q[0] <= ising_q;
      ovf_q[0]  <= (hi_ext >= den_ext);
      idx_q[0]  <= iidx_q;

      for (int i = 0; i < W; i++) begin
        if ({rem_q[i], low_q[i][W-1]} >= {1'b0, den_q[i]}) begin
          rem_q[i+1] <= DW'({rem_q[i], low_q[i][W-1]} - {1'b0, den_q[i]});
          quo_q[i+1] <= {quo_q[i][W-2:0], 1'b1};
        end else begin
          rem_q[i+1] <= {rem_q[i][DW-2:0], low_q[i][W-1]};
          quo_q[i+1] <= {quo_q[i][W-2:0], 1'b0};
        end
        low_q[i+1]  <= {low_q[i][W-2:0], 1'b0};
        den_q[i+1]  <= den_q[i];
        neg_q[i+1]  <= neg_q[i];
        sing_q[i+1] <= sing_q[i];
        ovf_q[i+1]  <= ovf_q[i];
        idx_q[i+1]  <= idx_q[i];
      end
    end
  end

  // Saturate, apply the sign and widen to the field.
  always_comb begin
    lim  = neg_q[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    mag  = (ovf_q[W] || (quo_q[W] > lim)) ? lim : quo_q[W];
    sres = neg_q[W] ? W'(-mag) : mag;
    res  = sing_q[W] ? '0 : FIELD_W'($signed(sres));
  end

  // Assembly buffer and output register.
  always_ff @(posedge clk_i) begin
    if (div_en && sv_q[W]) begin
      asm_q[idx_q[W]] <= res;
      if (idx_q[W] == LAST_IDX) asm_sing_q <= sing_q[W];
    end
    if (move) begin
      for (int k = 0; k < NUM_ELEMS; k++) out_data_q[k*FIELD_W +: FIELD_W] <= asm_q[k];
      out_sing_q <= asm_sing_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_singular_o = out_sing_q;

endmodule

// ----- hw/rtl/matrix3_inverse_unit.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse_unit
// Inverse of a 3x3 fixed-point matrix by the adjugate over the determinant,
// with saturated quotients and a singular flag.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         nine matrix elements, row-major, 32-bit fields
// m_axis    out        nine inverse elements, 32-bit fields; tuser singular
//
// In steady state the single pipelined divider produces one quotient per
// cycle while not held, so one matrix is taken per nine quotients.
// Reset clears every valid bit and the queue. A stall on m_axis holds the
// divider once a finished matrix waits; the front end keeps filling its
// two-entry queue until that is full.
// ----------------------------------------------------------------------------
module matrix3_inverse_unit import m3i_pkg::*; #(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // a_r0c0, a_r0c1, a_r0c2, a_r1c0 .. a_r2c2, 32 bits each from bit 0 up
  input  logic [NUM_ELEMS*FIELD_W-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0 .. inv_r2c2, 32 bits each
  output logic [NUM_ELEMS*FIELD_W-1:0] m_axis_tdata,
  // singular
  output logic                         m_axis_tuser
);

  localparam int unsigned CW = 2 * ELEM_WIDTH + 1;
  localparam int unsigned DW = 3 * ELEM_WIDTH + 3;
  localparam int unsigned QW = NUM_ELEMS * CW + DW;

  logic                      fe_valid, fe_ready, be_valid, be_ready;
  logic [NUM_ELEMS*CW-1:0]   fe_adj, be_adj;
  logic [DW-1:0]             fe_det, be_det;

  m3i_front #(
    .ElemWidth (ELEM_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (fe_valid),
    .out_ready_i (fe_ready),
    .out_adj_o   (fe_adj),
    .out_det_o   (fe_det)
  );

  m3i_queue #(
    .DataWidth (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  ({fe_det, fe_adj}),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_data_o   ({be_det, be_adj})
  );

  m3i_back #(
    .ElemWidth (ELEM_WIDTH),
    .FracBits  (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (be_valid),
    .in_ready_o     (be_ready),
    .in_adj_i       (be_adj),
    .in_det_i       (be_det),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata),
    .out_singular_o (m_axis_tuser)
  );

endmodule

// ----- dv/matrix3_inverse_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_checker
// Watches both stream channels of the matrix inverse unit. It works out the
// expected inverse of every matrix accepted on s_axis and compares each
// transfer on m_axis, element by element and on the singular flag.
// ----------------------------------------------------------------------------
module matrix3_inverse_checker import m3i_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [NUM_ELEMS*FIELD_W-1:0] s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [NUM_ELEMS*FIELD_W-1:0] m_axis_tdata,
  input  logic                         m_axis_tuser,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           results_o,
  output int                           singular_seen_o,
  output int                           saturated_seen_o
);

  typedef struct packed {
    logic                         singular;
    logic [NUM_ELEMS*FIELD_W-1:0] elems;
  } inverse_t;

  inverse_t expected_inverses[$];

  // Exact inverse: cofactors at 32 fraction bits, determinant at 48.
  function automatic inverse_t compute_inverse(logic [NUM_ELEMS*FIELD_W-1:0] mat);
    logic signed [31:0]  a [NUM_ELEMS];
    logic signed [127:0] cof [NUM_ELEMS];
    logic signed [127:0] det;
    logic [127:0]        num_mag, det_mag, quo;
    logic                neg;
    logic [31:0]         q;
    inverse_t            res;
    for (int k = 0; k < NUM_ELEMS; k++) a[k] = mat[k*FIELD_W +: FIELD_W];
    for (int k = 0; k < NUM_ELEMS; k++)
      cof[k] = 128'(a[ADJ_IDX[k][0]]) * 128'(a[ADJ_IDX[k][1]])
             - 128'(a[ADJ_IDX[k][2]]) * 128'(a[ADJ_IDX[k][3]]);
    det = 128'(a[0]) * cof[0] + 128'(a[1]) * cof[3] + 128'(a[2]) * cof[6];
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    det_mag = det[127] ? -det : det;
    for (int k = 0; k < NUM_ELEMS; k++) begin
      num_mag = cof[k][127] ? -cof[k] : cof[k];
      num_mag = num_mag << 32;
      neg = cof[k][127] ^ det[127];
      quo = num_mag / det_mag;
      if (quo == 0) q = '0;
      else if (neg) q = (quo > 128'h8000_0000) ? 32'h8000_0000 : 32'(-quo);
      else q = (quo > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
      res.elems[k*FIELD_W +: FIELD_W] = q;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    results_o = 0;
    singular_seen_o = 0;
    saturated_seen_o = 0;
  end

  assign pending_o = expected_inverses.size();

  // Record each matrix transfer and check each result transfer.
  always @(posedge clk_i) begin
    inverse_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_inverses.push_back(compute_inverse(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (expected_inverses.size() == 0) begin
          $display("%0t result transfer with no matrix outstanding", $realtime);
          fail_count_o++;
        end else begin
          want = expected_inverses.pop_front();
          if (want.singular) singular_seen_o++;
          for (int k = 0; k < NUM_ELEMS; k++) begin
            if (want.elems[k*FIELD_W +: FIELD_W] inside {32'h7FFF_FFFF, 32'h8000_0000})
              saturated_seen_o++;
            if (m_axis_tdata[k*FIELD_W +: FIELD_W] !== want.elems[k*FIELD_W +: FIELD_W])
              report_mismatch($sformatf("inverse element %0d", k),
                              m_axis_tdata[k*FIELD_W +: FIELD_W],
                              want.elems[k*FIELD_W +: FIELD_W]);
          end
          if (m_axis_tuser !== want.singular)
            report_mismatch("singular flag", 32'(m_axis_tuser), 32'(want.singular));
        end
      end
    end
  end

endmodule

// ----- dv/matrix3_inverse_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_unit_tb
// Feeds directed and random 3x3 matrices to the inverse unit with random
// gaps and output stalls; a checker beside the unit predicts every result.
// ----------------------------------------------------------------------------
module matrix3_inverse_unit_tb import m3i_pkg::*;;

  localparam int RANDOM_ITEMS = 430;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [NUM_ELEMS*FIELD_W-1:0] s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [NUM_ELEMS*FIELD_W-1:0] m_axis_tdata;
  logic                         m_axis_tuser;
  int fail_count, pending, results, singular_seen, saturated_seen;
  int cycle_count = 0;
  int sent = 0;

  always #10 clk_i = ~clk_i;

  matrix3_inverse_unit dut (.*);

  matrix3_inverse_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .singular_seen_o(singular_seen), .saturated_seen_o(saturated_seen)
  );

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("matrix3_inverse_unit_tb failed");
      $finish;
    end
  end

  // Result side: a random stall before each transfer, with calm stretches.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      repeat (stall) @(posedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      m_axis_tready <= 1'b0;
    end
  end

  // Drive one matrix and hold it until the transfer completes.
  task automatic send_matrix(logic [NUM_ELEMS*FIELD_W-1:0] mat);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= mat;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  function automatic logic [31:0] random_elem();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 512)) - 256);
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4: return '0;
      default: return 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
    endcase
  endfunction

  function automatic logic [NUM_ELEMS*FIELD_W-1:0] random_matrix();
    logic [NUM_ELEMS*FIELD_W-1:0] m;
    for (int k = 0; k < NUM_ELEMS; k++) m[k*FIELD_W +: FIELD_W] = random_elem();
    // Now and then copy one row onto another so the determinant vanishes.
    if ($urandom_range(0, 9) == 0) m[96 +: 96] = m[0 +: 96];
    return m;
  endfunction

  initial begin
    logic [NUM_ELEMS*FIELD_W-1:0] m;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity, a mixed diagonal, zero, all-ones bits and the field extremes.
    m = '0;
    m[0 +: 32] = ONE; m[128 +: 32] = ONE; m[256 +: 32] = ONE;
    send_matrix(m);
    m[0 +: 32] = 32'h0002_0000; m[128 +: 32] = 32'hFFFC_0000; m[256 +: 32] = 32'h0000_8000;
    send_matrix(m);
    send_matrix('0);
    send_matrix('1);
    m = '0;
    m[0 +: 32] = 32'h8000_0000; m[128 +: 32] = 32'h8000_0000; m[256 +: 32] = 32'h8000_0000;
    send_matrix(m);
    m[0 +: 32] = 32'h7FFF_FFFF; m[128 +: 32] = 32'h7FFF_FFFF; m[256 +: 32] = 32'h7FFF_FFFF;
    send_matrix(m);
    // Tiny diagonal: inverse elements saturate both ways.
    m = '0;
    m[0 +: 32] = 32'd1; m[128 +: 32] = 32'hFFFF_FFFF; m[256 +: 32] = 32'd1;
    send_matrix(m);
    // Huge diagonal: the inverse elements come out tiny but not zero.
    m[0 +: 32] = 32'h7FFF_FFFF; m[128 +: 32] = 32'h8000_0000; m[256 +: 32] = 32'h7FFF_FFFF;
    send_matrix(m);
    // Permutation matrix with a negative entry.
    m = '0;
    m[32 +: 32] = ONE; m[96 +: 32] = -ONE; m[256 +: 32] = ONE;
    send_matrix(m);
    // Equal rows: singular.
    for (int k = 0; k < 3; k++) begin
      m[k*32 +: 32] = ONE * (k + 1); m[96 + k*32 +: 32] = ONE * (k + 1);
      m[192 + k*32 +: 32] = 32'h0003_8000;
    end
    send_matrix(m);
    for (int k = 0; k < NUM_ELEMS; k++) m[k*32 +: 32] = 32'h8000_0000 >> k;
    send_matrix(m);
    for (int k = 0; k < NUM_ELEMS; k++) m[k*32 +: 32] = 32'h5555_5555 ^ (k * 32'h1111);
    send_matrix(m);

    for (int i = 0; i < RANDOM_ITEMS; i++) send_matrix(random_matrix());
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d matrices, checked %0d results", sent, results);
    $display("%0d singular, %0d saturated elements seen", singular_seen, saturated_seen);
    if (fail_count == 0 && results == sent)
      $display("matrix3_inverse_unit_tb passed");
    else
      $display("matrix3_inverse_unit_tb failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/m3i_pkg.sv
hw/rtl/m3i_front.sv
hw/rtl/m3i_queue.sv
hw/rtl/m3i_back.sv
hw/rtl/matrix3_inverse_unit.sv
dv/matrix3_inverse_checker.sv
dv/matrix3_inverse_unit_tb.sv
